// ===== design/osh_pkg.sv =====
// Shared types and constants for the outline stencil highlight block.
`timescale 1ns / 1ps
`default_nettype none

package osh_pkg;

	// Sizes of the frame and of the fields
	localparam int MAX_WIDTH_DEF = 4096;
	localparam int MAX_HEIGHT    = 4096;
	localparam int DIM_W         = 13;
	localparam int ID_W          = 32;
	localparam int COLOR_W       = 32;

	// Configuration port
	localparam int REG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_OUTLINE_ID   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_PASS_ENABLE  = 2'd3;

	// Request kinds on the pixel channel
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	// Pixel request payload
	typedef struct packed {
		logic               action;
		logic [ID_W-1:0]    object_id;
		logic [COLOR_W-1:0] pixel_color;
	} osh_pixel_t;

	// Result request payload
	typedef struct packed {
		logic [COLOR_W-1:0] out_color;
		logic               highlighted;
		logic               frame_end;
	} osh_result_t;

endpackage

`default_nettype wire

// ===== design/osh_stream_if.sv =====
// Valid/ready stream interface used by the pixel and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface osh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/outline_stencil_highlight_core.sv =====
// Outline stencil highlight: 3x3 match count over a pixel stream with line stores.
//
// Pixel requests (pixel channel) arrive in raster order, each an object id and an
// RGBA8 color; drain requests after the last pixel flush the final row. The block
// counts pixels whose id equals outline_id in the border-clipped 3x3 window around
// each pixel and, for a count of 2 to 7 with the pass enabled, shades the color
// toward orange. Results (result channel) lag the pixel stream by one row plus one
// pixel; the early requests of a frame give no result.
// One request is taken every clock unless the pipeline stalls: the line store is
// a single memory read at the request's column when it is taken and written back
// when the request leaves stage 1, with the write forwarded when the next request
// hits the same column. The output register takes a result when the request that
// releases it leaves stage 1. While a waiting result is held there, requests that
// release no result still pass, and one that does parks in stage 1 and stalls the
// pixel channel until the waiting result leaves. Reset puts the registers at their
// reset values and the counters at the frame start. The line store is not cleared:
// entries not yet written in a frame only feed rows above the frame or centers
// that give no result. Configuration is written through wr_en, wr_index and
// wr_data, by the user only between frames; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module outline_stencil_highlight_core #(
	parameter int MAX_WIDTH = osh_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [osh_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [osh_pkg::CFG_DATA_W-1:0] wr_data,
	osh_stream_if.sink                           pixel,
	osh_stream_if.source                         result
);
	import osh_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CX_W   = COL_W + 1;
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = DIM_W;
	localparam int WORD_W = COLOR_W + 2;
	localparam logic [ROW_W-1:0] ROW_MAX = '1;

	// Configuration registers, sizes held already clamped
	logic [ID_W-1:0]  id_q;
	logic [WID_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             enable_q;
	logic [DIM_W-1:0] dim_in;

	assign dim_in = wr_data[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q     <= '1;
			width_q  <= WID_W'(1);
			height_q <= DIM_W'(1);
			enable_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_OUTLINE_ID: id_q <= wr_data[ID_W-1:0];
				REG_FRAME_WIDTH: begin
					if (dim_in == '0)
						width_q <= WID_W'(1);
					else if (32'(dim_in) > 32'(MAX_WIDTH))
						width_q <= WID_W'(MAX_WIDTH);
					else
						width_q <= WID_W'(dim_in);
				end
				REG_FRAME_HEIGHT: begin
					if (dim_in == '0)
						height_q <= DIM_W'(1);
					else if (32'(dim_in) > 32'(MAX_HEIGHT))
						height_q <= DIM_W'(MAX_HEIGHT);
					else
						height_q <= dim_in;
				end
				REG_PASS_ENABLE: enable_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Position decode for the incoming request
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CX_W-1:0]  wext, cext, c_inc;
	logic             col_zero, drain0, ignore0, last_col, emit0, fe0;
	logic             left_e, right_e, top_e, bottom_e;
	logic [8:0]       mask0;
	logic             match0;
	logic [COLOR_W-1:0] color0;
	logic             accept, take;

	assign wext     = CX_W'(width_q);
	assign cext     = {1'b0, col_q};
	assign c_inc    = cext + CX_W'(1);
	assign col_zero = (col_q == '0);
	assign drain0   = (row_q >= height_q);
	assign ignore0  = (pixel.payload.action == ACT_DRAIN) && !drain0;
	assign last_col = (c_inc >= wext);

	// The center is a row and a pixel back; at column zero, last column two rows up
	assign emit0    = col_zero ? (row_q >= ROW_W'(2)) : (row_q != '0);
	assign left_e   = col_zero ? (wext == CX_W'(1)) : (col_q == COL_W'(1));
	assign right_e  = col_zero ? 1'b1 : (cext >= wext);
	assign top_e    = col_zero ? (row_q < ROW_W'(3)) : (row_q < ROW_W'(2));
	assign bottom_e = col_zero ? (row_q > height_q) : (row_q >= height_q);
	assign fe0      = emit0 && (col_zero ? (row_q > height_q)
		: ((cext == wext) && (row_q >= height_q)));

	// Window bit index is column * 3 + row, left column and top row at zero
	assign mask0 = 9'h1FF & ~(left_e ? 9'h007 : 9'h000) & ~(right_e ? 9'h1C0 : 9'h000)
		& ~(top_e ? 9'h049 : 9'h000) & ~(bottom_e ? 9'h124 : 9'h000);

	assign match0 = !drain0 && (pixel.payload.object_id == id_q);
	assign color0 = drain0 ? '0 : pixel.payload.pixel_color;

	assign accept = pixel.valid && pixel.ready;
	assign take   = accept && !ignore0;

	// Column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (fe0) begin
				col_q <= '0;
				row_q <= '0;
			end else if (last_col) begin
				col_q <= '0;
				if (row_q != ROW_MAX)
					row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= c_inc[COL_W-1:0];
			end
		end
	end

	// Stage 1: read-modify-write of the line store
	logic               valid_s1, adv_s1;
	logic [COL_W-1:0]   addr_s1;
	logic               match_s1, emit_s1, fe_s1, fwd_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [8:0]         mask_s1;
	logic [WORD_W-1:0]  fwd_word_s1, rdata_q, rd_word, wr_word;
	logic               res_valid_q;
	osh_result_t        res_q;

	assign adv_s1      = valid_s1 && (!emit_s1 || !res_valid_q || result.ready);
	assign pixel.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (adv_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_s1     <= col_q;
			match_s1    <= match0;
			color_s1    <= color0;
			emit_s1     <= emit0;
			fe_s1       <= fe0;
			mask_s1     <= mask0;
			fwd_s1      <= valid_s1 && (addr_s1 == col_q);
			fwd_word_s1 <= wr_word;
		end
	end

	// Line store word: previous-row color, match two rows up in bit 0, one row up in bit 1
	logic [WORD_W-1:0] line_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (take)
			rdata_q <= line_mem[col_q];
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			line_mem[addr_s1] <= wr_word;
	end

	assign rd_word = fwd_s1 ? fwd_word_s1 : rdata_q;
	assign wr_word = {color_s1, match_s1, rd_word[1]};

	// Match window and center color
	logic [8:0]         win_q, win_next, win_hits;
	logic [COLOR_W-1:0] center_q;
	logic [3:0]         cnt;
	logic               hl;

	assign win_next = {match_s1, rd_word[1], rd_word[0], win_q[8:3]};
	assign win_hits = win_next & mask_s1;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < 9; i++)
			cnt = cnt + 4'(win_hits[i]);
	end

	assign hl = enable_q && (id_q != '1) && (cnt >= 4'd2) && (cnt <= 4'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q    <= '0;
			center_q <= '0;
		end else if (adv_s1) begin
			win_q    <= win_next;
			center_q <= rd_word[WORD_W-1:2];
		end
	end

	// 51/255 is 1/5 and each offset is a whole multiple of 255, so every channel is
	// its offset quotient plus floor(c/5); c*205 >> 10 is exact for 8-bit c.
	function automatic logic [7:0] div5(input logic [7:0] c);
		logic [15:0] p;
		p = 16'(c) * 16'd205;
		return 8'(p >> 10);
	endfunction

	function automatic logic [COLOR_W-1:0] shade(input logic [COLOR_W-1:0] c);
		logic [7:0] r, g, b, a;
		r = 8'd204 + div5(c[7:0]);
		g = 8'd102 + div5(c[15:8]);
		b = div5(c[23:16]);
		a = 8'd204 + div5(c[31:24]);
		return {a, b, g, r};
	endfunction

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv_s1 && emit_s1)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			res_q.out_color   <= hl ? shade(center_q) : center_q;
			res_q.highlighted <= hl;
			res_q.frame_end   <= fe_s1;
		end
	end

	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

`ifndef SYNTHESIS
	// The request that releases the frame's last result restarts the counters.
	assert property (@(posedge clk) disable iff (!arst_n)
		take && fe0 |=> (col_q == '0) && (row_q == '0))
		else $error("counters not cleared after frame end");

	// A shaded result only comes out with the pass enabled and a valid id.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.highlighted |-> enable_q && (id_q != '1))
		else $error("highlight while pass disabled");

	// A row wrap inside the frame moves one row down.
	assert property (@(posedge clk) disable iff (!arst_n)
		take && last_col && !fe0 && (row_q != ROW_MAX)
		|=> (col_q == '0) && (row_q == $past(row_q) + ROW_W'(1)))
		else $error("row counter did not advance on wrap");
`endif

endmodule

`default_nettype wire

// ===== verif/outline_stencil_highlight_core_test.sv =====
// Self-checking testbench for the outline stencil highlight core.
`timescale 1ns / 1ps
`default_nettype none

module outline_stencil_highlight_core_test;
	import osh_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  wr_en;
	logic [REG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	osh_stream_if #(.payload_t(osh_pixel_t))  pixel_ch ();
	osh_stream_if #(.payload_t(osh_result_t)) result_ch ();

	outline_stencil_highlight_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixel    (pixel_ch),
		.result   (result_ch)
	);

	// Register copies as the block should hold them.
	logic [31:0] cfg_outline_id;
	logic [12:0] cfg_width;
	logic [12:0] cfg_height;
	logic        cfg_enable;

	// Stencil state of the predictor: two rows of match bits and one row of colors.
	bit          match_top [MAX_WIDTH_DEF];
	bit          match_mid [MAX_WIDTH_DEF];
	bit   [31:0] color_row [MAX_WIDTH_DEF];
	logic [8:0]  match_window;
	logic [31:0] center_hold;
	int unsigned col_pos;
	int unsigned row_pos;

	// Pixel requests waiting to be sent and result requests still to come.
	osh_pixel_t  pixel_backlog[$];
	osh_result_t delayed_pixels[$];

	// Sender and receiver pacing.
	bit          gaps_on = 1'b0;
	logic [12:0] ready_pattern = '1;
	int unsigned ready_phase;
	int unsigned burst_left;
	int unsigned gap_left;

	// Run statistics.
	int unsigned mismatch_count = 0;
	int unsigned frame_items = 0;
	int unsigned frames_done = 0;
	int unsigned results_seen = 0;
	int unsigned shaded_seen = 0;

	// Clock.
	initial begin
		forever #5 clk = ~clk;
	end

	// A zero or oversized frame dimension is clamped into range.
	function automatic int unsigned clamp_dim(input logic [12:0] v, input int unsigned top);
		if (v == 13'd0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	// One channel moved 80% toward orange.
	function automatic logic [7:0] blend_toward_orange(input logic [7:0] c,
			input int unsigned k);
		int unsigned mixed;
		mixed = (51 * int'(c) + k) / 255;
		return mixed[7:0];
	endfunction

	function automatic logic [31:0] shade_orange(input logic [31:0] color);
		return {blend_toward_orange(color[31:24], 52020),
			blend_toward_orange(color[23:16], 0),
			blend_toward_orange(color[15:8], 26010),
			blend_toward_orange(color[7:0], 52020)};
	endfunction

	// Advance the stencil by one accepted request and queue the result it releases.
	task automatic step_stencil(input osh_pixel_t px);
		int unsigned w, h, c, cnt;
		int          rc, cc;
		bit          flushing, hit;
		logic [31:0] color, center;
		logic [8:0]  keep;
		osh_result_t res;
		w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		flushing = (row_pos >= h);
		c = col_pos;
		hit = 1'b0;
		color = '0;
		// Drains inside the frame are dropped; pixels after the frame act as drains.
		if (px.action == ACT_DRAIN && !flushing)
			return;
		if (!flushing) begin
			hit = (px.object_id == cfg_outline_id);
			color = px.pixel_color;
		end
		if (c >= MAX_WIDTH_DEF)
			c = 0;

		// Shift the new column into the window and update the line stores.
		match_window = {hit, match_mid[c], match_top[c], match_window[8:3]};
		match_top[c] = match_mid[c];
		match_mid[c] = hit;
		center = center_hold;
		center_hold = color_row[c];
		color_row[c] = color;

		// Position of the center pixel, one row and one pixel behind.
		if (c == 0) begin
			rc = int'(row_pos) - 2;
			cc = int'(w) - 1;
		end else begin
			rc = int'(row_pos) - 1;
			cc = int'(c) - 1;
		end
		if (c + 1 >= w) begin
			col_pos = 0;
			if (row_pos < 8191)
				row_pos++;
		end else begin
			col_pos = c + 1;
		end
		if (rc < 0)
			return;

		// Clip the window at the frame border and count the matches.
		keep = '1;
		if (cc < 1)
			keep &= ~9'h007;
		if (cc + 1 >= int'(w))
			keep &= ~9'h1C0;
		if (rc < 1)
			keep &= ~9'h049;
		if (rc + 1 >= int'(h))
			keep &= ~9'h124;
		cnt = $countones(match_window & keep);

		res.out_color = center;
		res.highlighted = 1'b0;
		if (cfg_enable && cfg_outline_id != '1 && cnt >= 2 && cnt <= 7) begin
			res.out_color = shade_orange(center);
			res.highlighted = 1'b1;
		end
		res.frame_end = 1'b0;
		if (cc == int'(w) - 1 && rc >= int'(h) - 1) begin
			res.frame_end = 1'b1;
			col_pos = 0;
			row_pos = 0;
			frames_done++;
		end
		delayed_pixels.push_back(res);
	endtask

	// Pixel sender: bursts of random length with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			pixel_ch.payload <= '0;
			burst_left = 0;
			gap_left = 0;
			match_window = '0;
			center_hold = '0;
			col_pos = 0;
			row_pos = 0;
		end else begin
			if (pixel_ch.valid && pixel_ch.ready)
				step_stencil(pixel_ch.payload);
			if (!pixel_ch.valid || pixel_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					pixel_ch.valid <= 1'b0;
				end else if (pixel_backlog.size() > 0) begin
					pixel_ch.valid <= 1'b1;
					pixel_ch.payload <= pixel_backlog.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = gaps_on ? $urandom_range(0, 6) : 0;
					end
				end else begin
					pixel_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: stalls follow a 13-bit ready pattern chosen per phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			ready_phase <= 0;
		end else begin
			result_ch.ready <= ready_pattern[ready_phase];
			ready_phase <= (ready_phase == 12) ? 0 : ready_phase + 1;
		end
	end

	task automatic flag_mismatch(input string what);
		if (mismatch_count < 50)
			$display("[%0t] mismatch: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Result checker: each result request against the oldest prediction.
	always @(posedge clk) begin
		osh_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen++;
			if (result_ch.payload.highlighted === 1'b1)
				shaded_seen++;
			if (delayed_pixels.size() == 0) begin
				flag_mismatch($sformatf("result color %08h with nothing pending",
					result_ch.payload.out_color));
			end else begin
				want = delayed_pixels.pop_front();
				if (result_ch.payload.out_color !== want.out_color)
					flag_mismatch($sformatf("out_color %08h, predicted %08h",
						result_ch.payload.out_color, want.out_color));
				if (result_ch.payload.highlighted !== want.highlighted)
					flag_mismatch($sformatf("highlighted %b, predicted %b",
						result_ch.payload.highlighted, want.highlighted));
				if (result_ch.payload.frame_end !== want.frame_end)
					flag_mismatch($sformatf("frame_end %b, predicted %b",
						result_ch.payload.frame_end, want.frame_end));
			end
		end
	end

	// A pixel matches the outline id with the given percent chance.
	function automatic osh_pixel_t make_pixel(input int unsigned density);
		osh_pixel_t px;
		int unsigned pick;
		px.action = ACT_PIXEL;
		if ($urandom_range(0, 99) < density)
			px.object_id = cfg_outline_id;
		else if ($urandom_range(0, 1) == 0)
			px.object_id = cfg_outline_id ^ (32'd1 << $urandom_range(0, 31));
		else
			px.object_id = $urandom();
		pick = $urandom_range(0, 7);
		px.pixel_color = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom();
		return px;
	endfunction

	function automatic osh_pixel_t drain_tick();
		osh_pixel_t px;
		px.action = ACT_DRAIN;
		px.object_id = $urandom();
		px.pixel_color = $urandom();
		return px;
	endfunction

	// Queue one frame and its flush; a noisy frame adds early drains and extra pixels.
	task automatic push_frame(input int unsigned density, input bit noisy);
		int unsigned w, h, n;
		w = clamp_dim(cfg_width, MAX_WIDTH_DEF);
		h = clamp_dim(cfg_height, MAX_HEIGHT);
		for (n = 0; n < w * h; n++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				pixel_backlog.push_back(drain_tick());
			pixel_backlog.push_back(make_pixel(density));
		end
		for (n = 0; n <= w; n++) begin
			if (noisy && $urandom_range(0, 4) == 0)
				pixel_backlog.push_back(make_pixel(density));
			else
				pixel_backlog.push_back(drain_tick());
		end
		frame_items += w * h + w + 1;
		// Drains after a completed frame give nothing.
		if (noisy)
			repeat ($urandom_range(0, 2)) pixel_backlog.push_back(drain_tick());
	endtask

	// Wait until every request is sent and every result is back, then let the block settle.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pixel_backlog.size() != 0 || pixel_ch.valid || delayed_pixels.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		case (idx)
			REG_OUTLINE_ID:   cfg_outline_id = value;
			REG_FRAME_WIDTH:  cfg_width = value[12:0];
			REG_FRAME_HEIGHT: cfg_height = value[12:0];
			REG_PASS_ENABLE:  cfg_enable = value[0];
			default: ;
		endcase
	endtask

	// Reprogram the block while idle, pick new pacing, and queue the phase's frames.
	task automatic run_phase(input logic [31:0] id, input logic [12:0] wdim,
			input logic [12:0] hdim, input bit en, input int unsigned density,
			input int unsigned frames, input bit noisy);
		wait_idle();
		write_reg(REG_OUTLINE_ID, id);
		write_reg(REG_FRAME_WIDTH, {19'($urandom()), wdim});
		write_reg(REG_FRAME_HEIGHT, {19'($urandom()), hdim});
		write_reg(REG_PASS_ENABLE, {31'($urandom()), en});
		@(posedge clk);
		wr_en <= 1'b0;
		gaps_on = ($urandom_range(0, 3) != 0);
		ready_pattern = ($urandom_range(0, 3) == 0) ? '1 : (13'($urandom()) | 13'h1);
		repeat (frames) push_frame(density, noisy);
	endtask

	// Stimulus: directed frames, then random phases.
	initial begin
		logic [31:0] id;
		logic [12:0] wdim, hdim;
		int unsigned pick, item_goal;
		wr_en = 1'b0;
		wr_index = REG_OUTLINE_ID;
		wr_data = '0;
		cfg_outline_id = '1;
		cfg_width = 13'd1;
		cfg_height = 13'd1;
		cfg_enable = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: a drain before any pixel is dropped, then a 1x1 frame passes.
		pixel_backlog.push_back(drain_tick());
		push_frame(50, 1'b0);
		// Fully matching 3x3 frame: corners and edges are shaded, the center is not.
		run_phase(32'h0, 13'd3, 13'd3, 1'b1, 100, 1, 1'b0);
		// Zero frame size is taken as 1x1; an all-ones id turns the pass off.
		run_phase('1, 13'd0, 13'd0, 1'b1, 100, 1, 1'b1);

		item_goal = frame_items + 1700;
		while (frame_items < item_goal) begin
			pick = $urandom_range(0, 7);
			id = (pick == 0) ? '1 : (pick == 1) ? '0 : $urandom();
			pick = $urandom_range(0, 9);
			wdim = (pick == 0) ? 13'd0 : (pick == 1) ? 13'($urandom_range(11, 40))
				: 13'($urandom_range(1, 10));
			pick = $urandom_range(0, 9);
			hdim = (pick == 0) ? 13'd0 : (pick == 1) ? 13'($urandom_range(7, 20))
				: 13'($urandom_range(1, 6));
			run_phase(id, wdim, hdim, $urandom_range(0, 3) != 0, $urandom_range(0, 100),
				$urandom_range(1, 3), $urandom_range(0, 1));
		end

		wait_idle();
		repeat (12) @(posedge clk);
		$display("Ran %0d frames over %0d pixel and flush requests.", frames_done,
			frame_items);
		$display("Checked %0d results, %0d of them shaded as outline.", results_seen,
			shaded_seen);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("Timed out with %0d results still pending.", delayed_pixels.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
